// ----- hw/rtl/mmir_pkg.sv -----
// Shared constants and types for the minmod interface reconstruction block.
`timescale 1ns / 1ps
`default_nettype none

package mmir_pkg;

    // Row length configuration register.
    localparam int ROW_LEN_W = 11;
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 11'd1024;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_SAMPLE_BITS = 32;

    // Row counter saturates once two complete rows sit in the line store.
    localparam int ROWS_W = 2;
    localparam logic [ROWS_W-1:0] ROWS_FULL = 2'd2;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [QCNT_W-1:0] level;
        logic              empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mmir_front.sv -----
// Front end: transaction acceptance, column tracking, line store and slope differences.
`timescale 1ns / 1ps
`default_nettype none

module mmir_front #(
    parameter int MAX_COLUMNS = mmir_pkg::DEF_MAX_COLUMNS,
    parameter int SAMPLE_BITS = mmir_pkg::DEF_SAMPLE_BITS,
    parameter int IN_TDATA_W  = 64,
    parameter int ENTRY_W     = 5 * SAMPLE_BITS + 5
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [mmir_pkg::ROW_LEN_W-1:0] cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [IN_TDATA_W-1:0]          s_tdata,
    input  wire logic [0:0]                     s_tuser,
    input  wire mmir_pkg::q_status_t            q_status,
    output logic                                push_valid,
    output logic [ENTRY_W-1:0]                  push_data
);

    localparam int W      = SAMPLE_BITS;
    localparam int DIFF_W = W + 1;
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int LEN_W  = (mmir_pkg::ROW_LEN_W > $clog2(MAX_COLUMNS + 1)) ?
                            mmir_pkg::ROW_LEN_W : $clog2(MAX_COLUMNS + 1);
    localparam int LINE_W = 4 * W;
    localparam int RDY_W  = mmir_pkg::QCNT_W + 1;

    logic [mmir_pkg::ROW_LEN_W-1:0] row_len_reg;
    logic [COL_W-1:0]               col_reg;
    logic [mmir_pkg::ROWS_W-1:0]    rows_reg;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [W-1:0]      s1_depth_reg;
    logic [W-1:0]      s1_level_reg;

    // Each entry holds the centre row (low half) and the older row (high half).
    logic [LINE_W-1:0] line_mem [MAX_COLUMNS];
    logic [LINE_W-1:0] line_rd_reg;
    logic [LINE_W-1:0] line_wr_data;

    logic [W-1:0]                depth_in;
    logic [W-1:0]                level_in;
    logic                        frame_start;
    logic [LEN_W-1:0]            len_ext;
    logic [LEN_W-1:0]            len_eff;
    logic [COL_W-1:0]            cur_col;
    logic [mmir_pkg::ROWS_W-1:0] cur_rows;
    logic                        cur_last;
    logic                        cur_emit;
    logic                        accept;

    logic [W-1:0]      hc;
    logic [W-1:0]      zc;
    logic [W-1:0]      ho;
    logic [W-1:0]      zo;
    logic [DIFF_W-1:0] dh1;
    logic [DIFF_W-1:0] dz1;
    logic [DIFF_W-1:0] dh2;
    logic [DIFF_W-1:0] dz2;

    assign depth_in    = s_tdata[W-1:0];
    assign level_in    = s_tdata[2*W-1:W];
    assign frame_start = s_tuser[0];

    always_comb begin
        len_ext = LEN_W'(row_len_reg);
        if (len_ext == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_ext > LEN_W'(MAX_COLUMNS)) begin
            len_eff = LEN_W'(MAX_COLUMNS);
        end else begin
            len_eff = len_ext;
        end
    end

    assign cur_col  = frame_start ? '0 : col_reg;
    assign cur_rows = frame_start ? '0 : rows_reg;
    assign cur_last = (LEN_W'(cur_col) + LEN_W'(1)) >= len_eff;
    assign cur_emit = cur_rows >= mmir_pkg::ROWS_FULL;

    // Room is reserved for the entry in flight as well as the one being accepted.
    assign s_tready = (RDY_W'(q_status.level) + RDY_W'(s1_emit_reg))
                      < RDY_W'(mmir_pkg::QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_len_reg  <= mmir_pkg::ROW_LEN_RESET;
            col_reg      <= '0;
            rows_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                row_len_reg <= cfg_wr_data;
            end
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && cur_emit;
            if (accept) begin
                if (cur_last) begin
                    col_reg  <= '0;
                    rows_reg <= cur_emit ? cur_rows : cur_rows + 1'b1;
                end else begin
                    col_reg  <= cur_col + 1'b1;
                    rows_reg <= cur_rows;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_last_reg  <= cur_last;
            s1_col_reg   <= cur_col;
            s1_depth_reg <= depth_in;
            s1_level_reg <= level_in;
        end
    end

    // The old centre moves to the older half and the new sample becomes centre.
    assign line_wr_data = {line_rd_reg[2*W-1:W], line_rd_reg[W-1:0],
                           s1_level_reg, s1_depth_reg};

    // Line store: written in the cycle after the read; a read of the column being
    // written in the same cycle takes the new word instead of the stale one.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= line_wr_data;
        end
        if (accept) begin
            if (s1_valid_reg && (s1_col_reg == cur_col)) begin
                line_rd_reg <= line_wr_data;
            end else begin
                line_rd_reg <= line_mem[cur_col];
            end
        end
    end

    assign hc = line_rd_reg[W-1:0];
    assign zc = line_rd_reg[2*W-1:W];
    assign ho = line_rd_reg[3*W-1:2*W];
    assign zo = line_rd_reg[4*W-1:3*W];

    assign dh1 = {hc[W-1], hc} - {s1_depth_reg[W-1], s1_depth_reg};
    assign dz1 = {zc[W-1], zc} - {s1_level_reg[W-1], s1_level_reg};
    assign dh2 = {ho[W-1], ho} - {hc[W-1], hc};
    assign dz2 = {zo[W-1], zo} - {zc[W-1], zc};

    assign push_valid = s1_emit_reg;
    assign push_data  = {s1_last_reg, zc, dh1, dz1, dh2, dz2};

endmodule

`default_nettype wire

// ----- hw/rtl/mmir_queue.sv -----
// Short FIFO between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module mmir_queue #(
    parameter int DATA_W = 165
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic          pop,
    output logic [DATA_W-1:0]  head_data,
    output mmir_pkg::q_status_t status
);

    logic [DATA_W-1:0]           slot_reg [mmir_pkg::QUEUE_DEPTH];
    logic [mmir_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mmir_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mmir_pkg::QCNT_W-1:0] level_reg;
    logic [mmir_pkg::QCNT_W-1:0] level_next;

    always_comb begin
        level_next = level_reg;
        if (push_valid && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push_valid && pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = slot_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = (level_reg == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/mmir_back.sv -----
// Back end: minmod limiting, half step, saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none

module mmir_back #(
    parameter int SAMPLE_BITS = mmir_pkg::DEF_SAMPLE_BITS,
    parameter int ENTRY_W     = 5 * SAMPLE_BITS + 5,
    parameter int OUT_TDATA_W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [ENTRY_W-1:0]  head_data,
    input  wire mmir_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OUT_TDATA_W-1:0]   m_tdata,
    output logic                     m_tlast
);

    localparam int W      = SAMPLE_BITS;
    localparam int DIFF_W = W + 1;
    localparam int SUM_W  = W + 2;
    localparam int DLT_W  = W + 3;
    localparam int RES_W  = W + 4;

    // Same-sign operands compare correctly as unsigned words.
    function automatic logic [SUM_W-1:0] minmod(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] r;
        if (a[SUM_W-1] != b[SUM_W-1]) begin
            r = '0;
        end else if (!a[SUM_W-1]) begin
            r = (a < b) ? a : b;
        end else begin
            r = (a > b) ? a : b;
        end
        return r;
    endfunction

    logic [DIFF_W-1:0] in_dz2;
    logic [DIFF_W-1:0] in_dh2;
    logic [DIFF_W-1:0] in_dz1;
    logic [DIFF_W-1:0] in_dh1;
    logic [W-1:0]      in_zc;
    logic              in_last;
    logic              adv;

    logic              b1_valid_reg;
    logic              b1_last_reg;
    logic [W-1:0]      b1_zc_reg;
    logic [SUM_W-1:0]  b1_sum1_reg;
    logic [SUM_W-1:0]  b1_sum2_reg;
    logic [SUM_W-1:0]  b1_dh1_reg;
    logic [SUM_W-1:0]  b1_dh2_reg;

    logic              b2_valid_reg;
    logic              b2_last_reg;
    logic [W-1:0]      b2_zc_reg;
    logic [SUM_W-1:0]  b2_mm_sum_reg;
    logic [SUM_W-1:0]  b2_mm_dep_reg;

    logic              b3_valid_reg;
    logic              b3_last_reg;
    logic [W-1:0]      b3_zc_reg;
    logic [DLT_W-1:0]  b3_delta_reg;

    logic              out_valid_reg;
    logic              out_last_reg;
    logic [W-1:0]      out_level_reg;

    logic [DLT_W-1:0]  half_delta;
    logic [RES_W-1:0]  total;
    logic [W-1:0]      level_sat;

    assign in_dz2  = head_data[DIFF_W-1:0];
    assign in_dh2  = head_data[2*DIFF_W-1:DIFF_W];
    assign in_dz1  = head_data[3*DIFF_W-1:2*DIFF_W];
    assign in_dh1  = head_data[4*DIFF_W-1:3*DIFF_W];
    assign in_zc   = head_data[4*DIFF_W+W-1:4*DIFF_W];
    assign in_last = head_data[4*DIFF_W+W];

    // The whole back end moves together whenever the output register can load.
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !q_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_comb begin
        half_delta = {b3_delta_reg[DLT_W-1], b3_delta_reg[DLT_W-1:1]};
        total      = {{4{b3_zc_reg[W-1]}}, b3_zc_reg} + {half_delta[DLT_W-1], half_delta};
        if ((&total[RES_W-1:W-1]) || !(|total[RES_W-1:W-1])) begin
            level_sat = total[W-1:0];
        end else if (total[RES_W-1]) begin
            level_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            level_sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_last_reg <= in_last;
            b1_zc_reg   <= in_zc;
            b1_sum1_reg <= {in_dz1[DIFF_W-1], in_dz1} + {in_dh1[DIFF_W-1], in_dh1};
            b1_sum2_reg <= {in_dz2[DIFF_W-1], in_dz2} + {in_dh2[DIFF_W-1], in_dh2};
            b1_dh1_reg  <= {in_dh1[DIFF_W-1], in_dh1};
            b1_dh2_reg  <= {in_dh2[DIFF_W-1], in_dh2};

            b2_last_reg   <= b1_last_reg;
            b2_zc_reg     <= b1_zc_reg;
            b2_mm_sum_reg <= minmod(b1_sum1_reg, b1_sum2_reg);
            b2_mm_dep_reg <= minmod(b1_dh1_reg, b1_dh2_reg);

            b3_last_reg  <= b2_last_reg;
            b3_zc_reg    <= b2_zc_reg;
            b3_delta_reg <= {b2_mm_sum_reg[SUM_W-1], b2_mm_sum_reg}
                            - {b2_mm_dep_reg[SUM_W-1], b2_mm_dep_reg};

            out_last_reg  <= b3_last_reg;
            out_level_reg <= level_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'(out_level_reg);

endmodule

`default_nettype wire

// ----- hw/rtl/minmod_interface_reconstruction.sv -----
// Top level of the minmod interface reconstruction block.
`timescale 1ns / 1ps
`default_nettype none

// Depth and level samples (signed Q16.16) arrive in raster order, one per
// transaction, and a single line store keeps the centre row and the older row
// for every column. Once two full rows are held, each new sample yields the
// lower-interface level of the centre row at its column: centre level plus half
// the difference between the minmod of the combined slopes and the minmod of the
// depth slopes, halved by an arithmetic shift and saturated to SAMPLE_BITS.
// Until two rows have been seen a sample produces no result but still fills the
// line store. Setting frame_start (tuser bit 0) makes that sample column 0 of a
// new grid. The row length register must be written by the user through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block itself does
// not enforce this. A value of 0 acts as 1 and values above MAX_COLUMNS act as
// MAX_COLUMNS; it resets to 1024. The block sustains one transaction per cycle
// while the queue has room: the line store is read in the accepting cycle and
// written back the next, with a bypass for a column revisited right away. A
// four-entry queue separates the front end from a four-stage arithmetic back
// end, and input keeps flowing while a finished result waits on m_tready until
// the queue fills. There is no clearing pass after reset: entries beyond a row
// length raised after rows were stored read as whatever they held.
module minmod_interface_reconstruction #(
    parameter int MAX_COLUMNS = mmir_pkg::DEF_MAX_COLUMNS,
    parameter int SAMPLE_BITS = mmir_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Row length register write.
    input  wire logic                           cfg_wr_en,
    input  wire logic [mmir_pkg::ROW_LEN_W-1:0] cfg_wr_data,
    // Sample stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: depth_sample, level_sample, zero padding.
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0 up: frame_start.
    input  wire logic [0:0]                     s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0 up: interface_level, zero padding.
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    // row_done: set on the result for the last column of a row.
    output logic                                m_tlast
);

    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    // Queue entry: slope differences (four), centre level and the row end flag.
    localparam int ENTRY_W     = 5 * SAMPLE_BITS + 5;

    logic                q_push_valid;
    logic [ENTRY_W-1:0]  q_push_data;
    logic                q_pop;
    logic [ENTRY_W-1:0]  q_head_data;
    mmir_pkg::q_status_t q_status;

    // Front end: accepts transactions, tracks column and row count, reads and
    // updates the line store and forms the four slope differences.
    mmir_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_TDATA_W  (IN_TDATA_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_status    (q_status),
        .push_valid  (q_push_valid),
        .push_data   (q_push_data)
    );

    // Only samples that produce a result enter the queue.
    mmir_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_data  (q_head_data),
        .status     (q_status)
    );

    // Back end: limiter arithmetic and the registered result port.
    mmir_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_data (q_head_data),
        .q_status  (q_status),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mmir_checker.sv -----
// Port-level assertions for the minmod interface reconstruction block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module mmir_checker #(
    parameter int OUT_TDATA_W = 32
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [OUT_TDATA_W-1:0]         m_tdata,
    input wire logic                           m_tlast
);

    localparam int OWED_W = 16;

    // Accepted samples minus delivered results; sticks once it saturates.
    logic [OWED_W-1:0] owed_reg;
    logic [OWED_W-1:0] owed_next;
    logic              in_xfer;
    logic              out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb begin
        owed_next = owed_reg;
        if (owed_reg != '1) begin
            if (in_xfer && !out_xfer) begin
                owed_next = owed_reg + 1'b1;
            end else if (!in_xfer && out_xfer) begin
                owed_next = owed_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= '0;
        end else begin
            owed_reg <= owed_next;
        end
    end

    // A stalled result holds its value and row end flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the result path.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // After reset the queue is empty, so samples are taken at once.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // No result is offered without a sample accepted for it.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> owed_reg != '0)
        else $error("result offered with no sample owed");

endmodule

bind minmod_interface_reconstruction mmir_checker #(
    .OUT_TDATA_W (OUT_TDATA_W)
) u_mmir_checker (.*);

`default_nettype wire

// ----- tb/interface_level_checker.sv -----
// Checker that predicts the reconstructed interface levels and compares them with the block's results.
`timescale 1ns / 1ps

module interface_level_checker #(
    parameter int MAX_COLUMNS = mmir_pkg::DEF_MAX_COLUMNS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mmir_pkg::ROW_LEN_W-1:0] cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [63:0]                   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [31:0]                   m_tdata,
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            pending_results
);

    localparam longint LEVEL_MAX = 64'sd2147483647;
    localparam longint LEVEL_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] level;
        logic        row_done;
    } level_result_t;

    level_result_t expected_levels[$];

    logic [31:0] older_depth  [MAX_COLUMNS];
    logic [31:0] centre_depth [MAX_COLUMNS];
    logic [31:0] older_level  [MAX_COLUMNS];
    logic [31:0] centre_level [MAX_COLUMNS];

    logic [mmir_pkg::ROW_LEN_W-1:0] row_length;
    int column_pos;
    int rows_held;
    int errors = 0;
    int pending = 0;

    assign mismatch_count  = errors;
    assign pending_results = pending;

    function automatic longint slope_minmod(input longint a, input longint b);
        if (a >= 0 && b >= 0) begin
            return (a <= b) ? a : b;
        end
        if (a <= 0 && b <= 0) begin
            return (a >= b) ? a : b;
        end
        return 0;
    endfunction

    function automatic logic [31:0] predict_interface_level(
        input logic [31:0] hc, input logic [31:0] zc,
        input logic [31:0] ho, input logic [31:0] zo,
        input logic [31:0] hn, input logic [31:0] zn
    );
        longint dh1, dz1, dh2, dz2, diff, sum;
        dh1  = longint'($signed(hc)) - longint'($signed(hn));
        dz1  = longint'($signed(zc)) - longint'($signed(zn));
        dh2  = longint'($signed(ho)) - longint'($signed(hc));
        dz2  = longint'($signed(zo)) - longint'($signed(zc));
        diff = slope_minmod(dz1 + dh1, dz2 + dh2) - slope_minmod(dh1, dh2);
        sum  = longint'($signed(zc)) + (diff >>> 1);
        if (sum > LEVEL_MAX) begin
            sum = LEVEL_MAX;
        end else if (sum < LEVEL_MIN) begin
            sum = LEVEL_MIN;
        end
        return sum[31:0];
    endfunction

    always @(posedge aclk) begin : track
        level_result_t want;
        int len;
        int col;
        logic last;
        if (!aresetn) begin
            row_length = mmir_pkg::ROW_LEN_RESET;
            column_pos = 0;
            rows_held  = 0;
            expected_levels.delete();
        end else begin
            if (cfg_wr_en) begin
                row_length = cfg_wr_data;
            end

            // Results are retired before new expectations are queued, so an
            // early result can never match a sample taken on the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, got %h (row_done %b)",
                             $realtime, m_tdata, m_tlast);
                end else begin
                    want = expected_levels.pop_front();
                    if (m_tdata !== want.level || m_tlast !== want.row_done) begin
                        errors++;
                        $display("%0t: mismatch, expected %h (row_done %b), got %h (row_done %b)",
                                 $realtime, want.level, want.row_done, m_tdata, m_tlast);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                len = int'(row_length);
                if (len == 0) begin
                    len = 1;
                end else if (len > MAX_COLUMNS) begin
                    len = MAX_COLUMNS;
                end
                if (s_tuser[0]) begin
                    column_pos = 0;
                    rows_held  = 0;
                end
                col  = (column_pos >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : column_pos;
                last = (col + 1 >= len);
                if (rows_held >= 2) begin
                    want.level = predict_interface_level(centre_depth[col], centre_level[col],
                                                         older_depth[col], older_level[col],
                                                         s_tdata[31:0], s_tdata[63:32]);
                    want.row_done = last;
                    expected_levels.push_back(want);
                end
                older_depth[col]  = centre_depth[col];
                older_level[col]  = centre_level[col];
                centre_depth[col] = s_tdata[31:0];
                centre_level[col] = s_tdata[63:32];
                if (last) begin
                    column_pos = 0;
                    if (rows_held < 2) begin
                        rows_held++;
                    end
                end else begin
                    column_pos = col + 1;
                end
            end
        end
        pending <= expected_levels.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, sample stimulus, result stalls and the final verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_COLUMNS  = mmir_pkg::DEF_MAX_COLUMNS;
    localparam int FIRST_ITEMS  = 40;
    localparam int RANDOM_ITEMS = 1680;
    // The slowest legal run is a few thousand samples, each paying at most a
    // sender gap and a result stall, so this is ample.
    localparam int CYCLE_LIMIT  = 400000;
    // Margin for the path from sample to result, and for samples that make no
    // result and may still be in flight when the last result has gone out.
    localparam int DRAIN_CYCLES = 12;

    logic                           aclk;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [mmir_pkg::ROW_LEN_W-1:0] cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [63:0]                    s_tdata     = '0;
    logic [0:0]                     s_tuser     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [31:0]                    m_tdata;
    logic                           m_tlast;

    int mismatch_count;
    int pending_results;

    // Shadow of where the stream stands. It is used only to keep the stimulus
    // legal: a centre-row read must never hit a line store entry that has not
    // been written twice since reset, because such entries hold garbage.
    int  col_pos        = 0;
    int  rows_filled    = 0;
    int  active_len     = MAX_COLUMNS;
    byte column_writes[MAX_COLUMNS];
    int  burst_left     = 0;
    int  random_items   = 0;

    minmod_interface_reconstruction u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    interface_level_checker #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result backpressure. Every so often a new mode is chosen: always ready,
    // mostly ready, a coin toss, or a random eight-bit ready pattern that
    // repeats. The pattern always has at least one ready slot so results drain.
    int         stall_mode    = 0;
    int         stall_left    = 0;
    logic [7:0] stall_pattern = 8'hff;
    int         stall_phase   = 0;

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode    <= $urandom_range(0, 3);
            stall_left    <= $urandom_range(16, 96);
            stall_pattern <= 8'($urandom()) | 8'h01;
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= (stall_phase + 1) % 8;
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_tready <= ($urandom_range(0, 1) == 0);
            end
            default: begin
                m_tready <= stall_pattern[stall_phase];
            end
        endcase
    end

    // Sends one sample transaction. The sender runs in bursts; between bursts
    // tvalid drops for a random number of cycles. tvalid is only lowered when
    // the gap is nonzero, so it never gets two updates in one time step.
    task automatic send_sample(input logic [31:0] depth, input logic [31:0] level,
                               input logic frame_start);
        int   col;
        int   rows;
        int   gap;
        logic start;
        logic last;
        start = frame_start;
        col   = start ? 0 : col_pos;
        rows  = start ? 0 : rows_filled;
        // Reading an entry that was never written would be meaningless, so such
        // a sample is turned into the start of a fresh grid instead.
        if (rows >= 2 && column_writes[col] < 2) begin
            start = 1'b1;
            col   = 0;
            rows  = 0;
        end

        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end

        s_tvalid   <= 1'b1;
        s_tdata    <= {level, depth};
        s_tuser[0] <= start;
        do @(posedge aclk); while (!s_tready);
        burst_left--;

        if (column_writes[col] < 2) begin
            column_writes[col]++;
        end
        last = (col + 1 >= active_len);
        if (last) begin
            col_pos     = 0;
            rows_filled = (rows < 2) ? rows + 1 : rows;
        end else begin
            col_pos     = col + 1;
            rows_filled = rows;
        end
    endtask

    // Writes the row length while the block is idle: input held off, every
    // expected result delivered, and the pipeline given time to empty.
    task automatic write_row_length(input logic [mmir_pkg::ROW_LEN_W-1:0] value);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (value == 0) begin
            active_len = 1;
        end else if (int'(value) > MAX_COLUMNS) begin
            active_len = MAX_COLUMNS;
        end else begin
            active_len = int'(value);
        end
    endtask

    // Sample values: full-range noise, values hugging the numeric limits (so
    // the saturation paths fire), and small steps around a base so that slopes
    // of both signs, and exactly equal neighbors, are common.
    function automatic logic [31:0] random_sample(input logic [31:0] base);
        int spread;
        case ($urandom_range(0, 5))
            0, 1: begin
                random_sample = $urandom();
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       random_sample = 32'h7fff_ffff - $urandom_range(0, 3);
                    1:       random_sample = 32'h8000_0000 + $urandom_range(0, 3);
                    2:       random_sample = $urandom_range(0, 3);
                    default: random_sample = 32'hffff_ffff - $urandom_range(0, 3);
                endcase
            end
            default: begin
                spread = ($urandom_range(0, 1) == 0) ? 4 : 65536;
                random_sample = base + 32'(int'($urandom_range(0, 2 * spread)) - spread);
            end
        endcase
    endfunction

    initial begin : stimulus
        int          len_sel;
        int          phase_items;
        logic [10:0] len_value;
        logic        new_frame;
        logic [31:0] depth_base;
        logic [31:0] level_base;

        foreach (column_writes[i]) begin
            column_writes[i] = 0;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset row length: a partial first row of the widest grid. It makes
        // no results, and the columns it touches are written once; later
        // samples that would read a column not yet written twice start a new
        // grid instead.
        depth_base = 32'h0001_0000;
        level_base = 32'h0004_0000;
        for (int i = 0; i < FIRST_ITEMS; i++) begin
            send_sample(random_sample(depth_base), random_sample(level_base), i == 0);
        end

        // A zero row length acts as one column: every sample ends a row. The
        // samples sit at the limits of the Q16.16 range to force saturation.
        write_row_length(11'd0);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_sample(32'hffff_ffff, 32'h7fff_ffff, 1'b0);
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0000_8000, 1'b0);

        // An all-ones row length is clamped to the widest grid.
        write_row_length(11'h7ff);
        for (int i = 0; i < 6; i++) begin
            send_sample(32'(i * 3000 - 7000), 32'(20000 - i * i * 1500), 1'b0);
        end

        // Shrinking the row below the current column: the next sample is
        // treated as the last of its row.
        write_row_length(11'd3);
        send_sample(32'h0000_0001, 32'hffff_ffff, 1'b0);
        send_sample(32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0000_8000, 32'hffff_8000, 1'b0);
        send_sample(32'h0002_0000, 32'h0001_0000, 1'b0);

        // Random phases: mostly narrow grids so results come quickly, with the
        // occasional zero, clamped or near-maximum length. Streams mostly carry
        // on as well-formed rows, with a new grid started now and then.
        while (random_items < RANDOM_ITEMS) begin
            len_sel = $urandom_range(0, 39);
            if (len_sel == 0) begin
                len_value = 11'd0;
            end else if (len_sel == 1) begin
                len_value = 11'h7ff;
            end else if (len_sel == 2) begin
                len_value = 11'(MAX_COLUMNS - 1);
            end else if (len_sel == 3) begin
                len_value = 11'($urandom_range(MAX_COLUMNS, 2046));
            end else if (len_sel < 8) begin
                len_value = 11'($urandom_range(13, 64));
            end else begin
                len_value = 11'($urandom_range(1, 12));
            end
            write_row_length(len_value);

            phase_items = $urandom_range(1, 3 * active_len + 6);
            if (phase_items > 80) begin
                phase_items = 80;
            end
            new_frame  = (active_len <= 64) && ($urandom_range(0, 3) == 0);
            depth_base = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0040_0000);
            level_base = $urandom();
            for (int i = 0; i < phase_items; i++) begin
                send_sample(random_sample(depth_base), random_sample(level_base),
                            (i == 0 && new_frame) ||
                            (active_len <= 64 && $urandom_range(0, 63) == 0));
                random_items++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mmir_pkg.sv
hw/rtl/mmir_front.sv
hw/rtl/mmir_queue.sv
hw/rtl/mmir_back.sv
hw/rtl/minmod_interface_reconstruction.sv
hw/rtl/mmir_checker.sv
tb/interface_level_checker.sv
tb/testbench.sv
